>>> src/csbs_pkg.sv
package csbs_pkg;

    localparam int unsigned CAP_W      = 15;
    localparam int unsigned PWR_W      = 19;
    localparam int unsigned CUR_W      = 15;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned DVD_W      = 29;
    localparam int unsigned DIV_CNT_W  = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 19;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd29;

    localparam logic [CNT_W-1:0] FAULT_TICK_LIMIT = 7'd100;

    localparam logic [CAP_W-1:0] NF_LOW_MV    = 15'd9000;
    localparam logic [CAP_W-1:0] NF_MID_LO_MV = 15'd11000;
    localparam logic [CAP_W-1:0] NF_MID_HI_MV = 15'd18000;
    localparam logic [CAP_W-1:0] F_LOW_MV     = 15'd18000;
    localparam logic [CAP_W-1:0] F_MID_LO_MV  = 15'd19000;
    localparam logic [CAP_W-1:0] F_MID_HI_MV  = 15'd20000;
    localparam logic [CAP_W-1:0] FULL_MV      = 15'd20000;
    localparam logic [CAP_W-1:0] BOOST_ON_MV  = 15'd7000;
    localparam logic [CAP_W-1:0] BOOST_OFF_MV = 15'd5000;
    localparam logic [CAP_W-1:0] BOOST_MIN_MV = 15'd22000;

    localparam logic [CUR_W-1:0] ZERO_V_CURRENT_MA = 15'd500;
    localparam logic [9:0]       CURRENT_SCALE     = 10'd1000;

    localparam logic [PWR_W-1:0] MAX_POWER_RESET   = 19'd100000;
    localparam logic [CUR_W-1:0] MAX_CURRENT_RESET = 15'd10000;

    localparam logic [1:0] LEVEL_LOW  = 2'd0;
    localparam logic [1:0] LEVEL_MID  = 2'd1;
    localparam logic [1:0] LEVEL_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_POWER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_REQUEST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_REQUEST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT    = 3'd5;

    typedef struct packed {
        logic [CAP_W-1:0] cap_millivolts;
        logic [CAP_W-1:0] boost_millivolts;
    } in_item_t;

    typedef struct packed {
        logic             boost_on;
        logic             charger_on;
        logic             cap_output_on;
        logic [CUR_W-1:0] charge_current_ma;
        logic [1:0]       cap_level;
        logic             cap_ok;
        logic             boost_fault;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } seq_state_t;

endpackage

>>> src/csbs_div.sv
module csbs_div
    import csbs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [CAP_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [CAP_W-1:0]     rem_reg, rem_next;
    logic [CAP_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CAP_W:0]       rem_shift;
    logic [CAP_W:0]       diff;
    logic                 fits;

    always_comb begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = DIV_STEPS;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[CAP_W-1:0] : rem_shift[CAP_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> src/supercap_boost_charge_supervisor.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      in_item_t: capacitor and boost millivolts
// m_        out        m_valid / m_ready      out_item_t: enables, current, level, flags
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// For each item the sequencer loads the divider with power times 1000, runs 29 steps of the
// restoring divider for the charge current, and then hands the result to the output register.
// Reset is synchronous and active low; it resets the control registers but not the data registers.
// A result waits in the output register while the next item is accepted; a new result
// is held back only while the previous one has not been taken.
module supercap_boost_charge_supervisor
    import csbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic             run_mode_reg;
    logic [PWR_W-1:0] charge_power_reg;
    logic             charge_req_reg;
    logic             output_req_reg;
    logic [PWR_W-1:0] max_power_reg;
    logic [CUR_W-1:0] max_current_reg;

    seq_state_t state_reg, state_next;

    logic [1:0]       level_reg, level_next;
    logic             usable_reg, usable_next;
    logic             boost_en_reg, boost_en_next;
    logic             fault_reg, fault_next;
    logic [CNT_W-1:0] ticks_reg, ticks_next;

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [PWR_W-1:0] power_reg, power_next;
    out_item_t        pend_reg, pend_next;
    out_item_t        m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;

    logic             accept;
    logic             div_start;
    logic             out_load;
    logic             div_done;
    logic [DVD_W-1:0] dividend;
    logic [DVD_W-1:0] quotient;
    logic [CAP_W-1:0] lo_th, mid_lo, mid_hi;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign dividend  = DVD_W'(power_reg) * DVD_W'(CURRENT_SCALE);

    csbs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (cap_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_mode_reg     <= 1'b0;
            charge_power_reg <= '0;
            charge_req_reg   <= 1'b0;
            output_req_reg   <= 1'b0;
            max_power_reg    <= MAX_POWER_RESET;
            max_current_reg  <= MAX_CURRENT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RUN_MODE:       run_mode_reg     <= cfg_data[0];
                CFG_CHARGE_POWER:   charge_power_reg <= cfg_data[PWR_W-1:0];
                CFG_CHARGE_REQUEST: charge_req_reg   <= cfg_data[0];
                CFG_OUTPUT_REQUEST: output_req_reg   <= cfg_data[0];
                CFG_MAX_POWER:      max_power_reg    <= cfg_data[PWR_W-1:0];
                CFG_MAX_CURRENT:    max_current_reg  <= cfg_data[CUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_LOAD;
            end
            ST_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready   = 1'b1;
            ST_LOAD: div_start = 1'b1;
            ST_DIV:  ;
            ST_OUT:  out_load  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_comb begin
        lo_th  = fault_reg ? F_LOW_MV : NF_LOW_MV;
        mid_lo = fault_reg ? F_MID_LO_MV : NF_MID_LO_MV;
        mid_hi = fault_reg ? F_MID_HI_MV : NF_MID_HI_MV;

        level_next    = level_reg;
        usable_next   = usable_reg;
        boost_en_next = boost_en_reg;
        fault_next    = fault_reg;
        ticks_next    = ticks_reg;
        cap_next      = cap_reg;
        power_next    = power_reg;
        pend_next     = pend_reg;

        if (accept) begin
            cap_next = s_data.cap_millivolts;

            if (s_data.cap_millivolts < lo_th) begin
                level_next  = LEVEL_LOW;
                usable_next = 1'b0;
            end else if (s_data.cap_millivolts > mid_lo && s_data.cap_millivolts < mid_hi) begin
                level_next  = LEVEL_MID;
                usable_next = 1'b1;
            end else if (s_data.cap_millivolts > FULL_MV) begin
                level_next  = LEVEL_FULL;
                usable_next = 1'b1;
            end

            if (run_mode_reg) begin
                if (s_data.cap_millivolts > BOOST_ON_MV && !fault_reg) begin
                    boost_en_next = 1'b1;
                end else if (s_data.cap_millivolts < BOOST_OFF_MV) begin
                    boost_en_next = 1'b0;
                end
                if (boost_en_next && !fault_reg) begin
                    if (s_data.boost_millivolts < BOOST_MIN_MV) begin
                        if (ticks_reg >= FAULT_TICK_LIMIT) begin
                            fault_next    = 1'b1;
                            boost_en_next = 1'b0;
                        end else begin
                            ticks_next = ticks_reg + 1'b1;
                        end
                    end else begin
                        ticks_next = '0;
                    end
                end
                power_next = (charge_power_reg > max_power_reg) ? max_power_reg
                                                                : charge_power_reg;
            end else begin
                boost_en_next = 1'b0;
                power_next    = '0;
            end

            pend_next.boost_on      = boost_en_next;
            pend_next.charger_on    = run_mode_reg && charge_req_reg;
            pend_next.cap_output_on = run_mode_reg && output_req_reg && usable_next;
            pend_next.cap_level     = level_next;
            pend_next.cap_ok        = usable_next;
            pend_next.boost_fault   = fault_next;
        end

        if (state_reg == ST_DIV && div_done) begin
            if (cap_reg == '0) begin
                pend_next.charge_current_ma = (power_reg != '0) ? ZERO_V_CURRENT_MA : '0;
            end else if (quotient > DVD_W'(max_current_reg)) begin
                pend_next.charge_current_ma = max_current_reg;
            end else begin
                pend_next.charge_current_ma = quotient[CUR_W-1:0];
            end
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_data_next  = pend_reg;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cap_reg    <= cap_next;
        power_reg  <= power_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            level_reg    <= LEVEL_LOW;
            usable_reg   <= 1'b0;
            boost_en_reg <= 1'b0;
            fault_reg    <= 1'b0;
            ticks_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            usable_reg   <= usable_next;
            boost_en_reg <= boost_en_next;
            fault_reg    <= fault_next;
            ticks_reg    <= ticks_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/csbs_checker.sv
module csbs_checker
    import csbs_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed or dropped while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again while an item is in progress");

    a_level_usable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cap_ok == (m_data.cap_level != LEVEL_LOW))
                    && (m_data.cap_level <= LEVEL_FULL))
        else $error("capacitor level and usable flag disagree");

    a_fault_boost_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.boost_fault |-> !m_data.boost_on)
        else $error("boost enabled while fault latched");

endmodule

bind supercap_boost_charge_supervisor csbs_checker u_csbs_checker (.*);
